@@ hdl/ed2l_pkg.sv @@
`timescale 1ns / 1ps

package ed2l_pkg;

  // Fixed field widths
  localparam int MODE_W   = 2;
  localparam int QIDX_W   = 6;
  localparam int LETTER_W = 5;
  localparam int LEN_W    = 16;
  localparam int QLEN_W   = 7;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BEGIN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STEP  = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [QIDX_W-1:0]   query_index;
    logic [LETTER_W-1:0] query_letter;
    logic [LEN_W-1:0]    dict_length_a;
    logic [LEN_W-1:0]    dict_length_b;
    logic [LETTER_W-1:0] dict_letter_a;
    logic [LETTER_W-1:0] dict_letter_b;
  } item_t;

  typedef struct packed {
    logic [LEN_W-1:0] distance_a;
    logic [LEN_W-1:0] distance_b;
  } result_t;

  // Per-lane control from the sequencer
  typedef struct packed {
    logic start;
    logic step;
  } lane_ctl_t;

endpackage

@@ hdl/ed2l_qstore.sv @@
`timescale 1ns / 1ps

module ed2l_qstore #(
  parameter int QUERY_MAX     = 64,
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [ed2l_pkg::QIDX_W-1:0]   wr_index,
  input  logic [ed2l_pkg::LETTER_W-1:0] wr_letter,
  input  logic [ed2l_pkg::QLEN_W-1:0]   qlen,
  input  logic [ed2l_pkg::LETTER_W-1:0] letter_a,
  input  logic [ed2l_pkg::LETTER_W-1:0] letter_b,
  output logic [QUERY_MAX-1:0]          mask_a,
  output logic [QUERY_MAX-1:0]          mask_b
);

  // One register per query position, each compared at its own bit
  logic [ed2l_pkg::LETTER_W-1:0] letters [QUERY_MAX];
  logic                          ok_a;
  logic                          ok_b;

  always_ff @(posedge clk) begin
    if (wr_en && (32'(wr_index) < QUERY_MAX)) begin
      letters[wr_index] <= wr_letter;
    end
  end

  // Codes outside the alphabet match nothing
  assign ok_a = 32'(letter_a) < ALPHABET_SIZE;
  assign ok_b = 32'(letter_b) < ALPHABET_SIZE;

  // Match masks, limited to the live query length
  always_comb begin
    for (int i = 0; i < QUERY_MAX; i++) begin
      mask_a[i] = ok_a && (i < 32'(qlen)) && (letters[i] == letter_a);
      mask_b[i] = ok_b && (i < 32'(qlen)) && (letters[i] == letter_b);
    end
  end

endmodule

@@ hdl/ed2l_lane.sv @@
`timescale 1ns / 1ps

module ed2l_lane #(
  parameter int QUERY_MAX = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ed2l_pkg::lane_ctl_t         ctl,
  input  logic [ed2l_pkg::LEN_W-1:0]  length_in,
  input  logic [ed2l_pkg::LEN_W-1:0]  position,
  input  logic [ed2l_pkg::QLEN_W-1:0] qlen,
  input  logic [QUERY_MAX-1:0]        mask,
  output logic [ed2l_pkg::LEN_W-1:0]  length,
  output logic [ed2l_pkg::LEN_W-1:0]  score_next
);

  localparam int IW = (QUERY_MAX > 1) ? $clog2(QUERY_MAX) : 1;

  logic [QUERY_MAX-1:0]       vp;
  logic [QUERY_MAX-1:0]       vn;
  logic [ed2l_pkg::LEN_W-1:0] score;
  logic [QUERY_MAX-1:0]       x;
  logic [QUERY_MAX-1:0]       d0;
  logic [QUERY_MAX-1:0]       hn;
  logic [QUERY_MAX-1:0]       hp;
  logic [QUERY_MAX-1:0]       y;
  logic [QUERY_MAX-1:0]       vp_next;
  logic [QUERY_MAX-1:0]       vn_next;
  logic [IW-1:0]              top;
  logic                       active;

  // Myers column update
  assign x       = mask | vn;
  assign d0      = (((vp & x) + vp) ^ vp) | x;
  assign hn      = vp & d0;
  assign hp      = vn | ~(vp | d0);
  assign y       = (hp << 1) | QUERY_MAX'(1);
  assign vn_next = y & d0;
  assign vp_next = (hn << 1) | ~(y | d0);

  // Score follows the horizontal delta at the top query bit
  assign top    = IW'(qlen - 7'd1);
  assign active = position < length;

  always_comb begin
    score_next = score;
    if (ctl.step && active) begin
      if (qlen == '0) begin
        score_next = score + 16'd1;
      end else if (hp[top]) begin
        score_next = score + 16'd1;
      end else if (hn[top]) begin
        score_next = score - 16'd1;
      end
    end
    if (ctl.start) begin
      score_next = ed2l_pkg::LEN_W'(qlen);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vp     <= '1;
      vn     <= '0;
      score  <= '0;
      length <= '0;
    end else begin
      score <= score_next;
      if (ctl.start) begin
        vp     <= '1;
        vn     <= '0;
        length <= length_in;
      end else if (ctl.step) begin
        vp <= vp_next;
        vn <= vn_next;
      end
    end
  end

endmodule

@@ hdl/ed2l_merge.sv @@
`timescale 1ns / 1ps

module ed2l_merge (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       res_valid,
  input  logic [ed2l_pkg::LEN_W-1:0] score_a,
  input  logic [ed2l_pkg::LEN_W-1:0] score_b,
  input  logic                       result_stall,
  output logic                       result_valid,
  output ed2l_pkg::result_t          result,
  output logic                       item_stall
);

  ed2l_pkg::result_t res;
  ed2l_pkg::result_t skid;
  logic              skid_valid;
  logic              take;

  // Combine the two lane scores into one result
  assign res.distance_a = score_a;
  assign res.distance_b = score_b;

  assign take       = result_valid && !result_stall;
  assign item_stall = skid_valid;

  // Output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        result     <= skid;
        skid_valid <= 1'b0;
      end
    end else if (res_valid) begin
      if (!result_valid || take) begin
        result       <= res;
        result_valid <= 1'b1;
      end else begin
        skid       <= res;
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      result_valid <= 1'b0;
    end
  end

endmodule

@@ hdl/bit_parallel_edit_distance_two_lane_core.sv @@
`timescale 1ns / 1ps
// Channel  | Direction | Handshake              | Payload
// item     | in        | item_valid / item_stall | ed2l_pkg::item_t
// result   | out       | result_valid / result_stall | ed2l_pkg::result_t
// cfg      | in        | cfg_valid / cfg_ready  | query_length (7 bits)
//
// One request may be accepted each clock while item_stall is low. A step runs
// one QUERY_MAX-bit add per lane, which sets the clock period.
// A result is registered and appears the cycle after the request that ends it,
// unless a stalled result holds the output register; it then waits in the skid.
// rst is synchronous: vp vectors all ones, vn vectors, scores, lengths, position and
// query_length cleared; the query letter store holds no reset.
// item_stall rises only when both the output register and its skid entry hold
// results; cfg_ready is always high.

module bit_parallel_edit_distance_two_lane_core #(
  parameter int QUERY_MAX     = 64,
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  ed2l_pkg::item_t               item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output ed2l_pkg::result_t             result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ed2l_pkg::QLEN_W-1:0]   cfg_data
);

  logic [ed2l_pkg::QLEN_W-1:0] query_length;
  logic [ed2l_pkg::QLEN_W-1:0] qlen;
  logic [ed2l_pkg::LEN_W-1:0]  position;
  logic [ed2l_pkg::LEN_W-1:0]  position_next;
  logic [ed2l_pkg::LEN_W-1:0]  length_a;
  logic [ed2l_pkg::LEN_W-1:0]  length_b;
  logic [ed2l_pkg::LEN_W-1:0]  longest;
  logic [ed2l_pkg::LEN_W-1:0]  score_a;
  logic [ed2l_pkg::LEN_W-1:0]  score_b;
  logic [QUERY_MAX-1:0]        mask_a;
  logic [QUERY_MAX-1:0]        mask_b;
  logic                        accept;
  logic                        step_go;
  logic                        begin_go;
  logic                        res_valid;
  ed2l_pkg::lane_ctl_t         ctl;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      query_length <= cfg_data;
    end
  end

  // Effective query length, capped at the store depth
  assign qlen = (32'(query_length) > QUERY_MAX) ? ed2l_pkg::QLEN_W'(QUERY_MAX)
                                                : query_length;

  // Request decode
  assign accept   = item_valid && !item_stall;
  assign longest  = (length_a > length_b) ? length_a : length_b;
  assign begin_go = accept && (item.mode == ed2l_pkg::MODE_BEGIN);
  assign step_go  = accept && (item.mode == ed2l_pkg::MODE_STEP) && (position < longest);
  assign position_next = position + 16'd1;

  assign ctl.start = begin_go;
  assign ctl.step  = step_go;

  assign res_valid = (begin_go && (item.dict_length_a == '0) && (item.dict_length_b == '0))
                  || (step_go && (position_next == longest));

  // Position counter
  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (begin_go) begin
      position <= '0;
    end else if (step_go) begin
      position <= position_next;
    end
  end

  ed2l_qstore #(
    .QUERY_MAX    (QUERY_MAX),
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_qstore (
    .clk      (clk),
    .wr_en    (accept && (item.mode == ed2l_pkg::MODE_LOAD)),
    .wr_index (item.query_index),
    .wr_letter(item.query_letter),
    .qlen     (qlen),
    .letter_a (item.dict_letter_a),
    .letter_b (item.dict_letter_b),
    .mask_a   (mask_a),
    .mask_b   (mask_b)
  );

  ed2l_lane #(
    .QUERY_MAX(QUERY_MAX)
  ) u_lane_a (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .length_in (item.dict_length_a),
    .position  (position),
    .qlen      (qlen),
    .mask      (mask_a),
    .length    (length_a),
    .score_next(score_a)
  );

  ed2l_lane #(
    .QUERY_MAX(QUERY_MAX)
  ) u_lane_b (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .length_in (item.dict_length_b),
    .position  (position),
    .qlen      (qlen),
    .mask      (mask_b),
    .length    (length_b),
    .score_next(score_b)
  );

  ed2l_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .res_valid   (res_valid),
    .score_a     (score_a),
    .score_b     (score_b),
    .result_stall(result_stall),
    .result_valid(result_valid),
    .result      (result),
    .item_stall  (item_stall)
  );

  // Position never runs past the longer word
  a_pos_bound: assert property (@(posedge clk) disable iff (rst) position <= longest)
    else $error("position beyond longest length");

  // Input is held back only while a result is waiting
  a_stall_holds_result: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid)
    else $error("stall with no pending result");

  // A finishing step leaves the position at the longer length
  a_finish_pos: assert property (@(posedge clk) disable iff (rst)
    (step_go && res_valid) |=> (position == longest))
    else $error("finishing step left position off the end");

  // After any result is produced, result_valid is high on the next cycle
  a_result_out: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> result_valid)
    else $error("result lost");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int QMAX = 64;
  localparam int ALPHA = 26;
  localparam logic [ed2l_pkg::MODE_W-1:0] MODE_NOP = 2'd3;  // ignored by the block
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 500000;

  logic clk;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  ed2l_pkg::item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  ed2l_pkg::result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ed2l_pkg::QLEN_W-1:0] cfg_data = '0;

  bit_parallel_edit_distance_two_lane_core dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  // Predicted block state
  logic [ed2l_pkg::LETTER_W-1:0] qstore [QMAX];
  logic [63:0] vplus [2];
  logic [63:0] vminus [2];
  logic [ed2l_pkg::LEN_W-1:0] score [2];
  logic [ed2l_pkg::LEN_W-1:0] word_len [2];
  logic [ed2l_pkg::LEN_W-1:0] pos;
  logic [ed2l_pkg::QLEN_W-1:0] query_len;

  // Stimulus side: pending requests and expected distances
  ed2l_pkg::item_t pending_q [$];
  ed2l_pkg::result_t dist_q [$];
  logic [ed2l_pkg::LETTER_W-1:0] query_shadow [QMAX];
  bit query_set [QMAX];
  int shadow_m;
  int n_items;
  int n_errors;
  int cycles;
  logic hold_start = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // One Myers column update for one lane
  task automatic column_update(input int ln, input logic [ed2l_pkg::LETTER_W-1:0] letter,
                               input int m);
    logic [63:0] eq, x, d0, hn, hp, y;
    eq = '0;
    if (letter < ALPHA) begin
      for (int i = 0; i < m; i++)
        if (qstore[i] == letter) eq[i] = 1'b1;
    end
    x = eq | vminus[ln];
    d0 = (((vplus[ln] & x) + vplus[ln]) ^ vplus[ln]) | x;
    hn = vplus[ln] & d0;
    hp = vminus[ln] | ~(vplus[ln] | d0);
    y = (hp << 1) | 64'd1;
    vminus[ln] = y & d0;
    vplus[ln] = (hn << 1) | ~(y | d0);
    // score frozen once the lane's word is used up
    if (pos < word_len[ln]) begin
      if (m == 0) score[ln] = score[ln] + 16'd1;
      else if (hp[m-1]) score[ln] = score[ln] + 16'd1;
      else if (hn[m-1]) score[ln] = score[ln] - 16'd1;
    end
  endtask

  // Apply one accepted request to the predicted state
  task automatic advance_model(input ed2l_pkg::item_t it);
    logic [ed2l_pkg::LEN_W-1:0] longest;
    int m;
    ed2l_pkg::result_t r;
    m = (query_len > QMAX) ? QMAX : int'(query_len);
    longest = (word_len[0] > word_len[1]) ? word_len[0] : word_len[1];
    case (it.mode)
      ed2l_pkg::MODE_LOAD: begin
        qstore[it.query_index] = it.query_letter;
      end
      ed2l_pkg::MODE_BEGIN: begin
        for (int k = 0; k < 2; k++) begin
          vplus[k] = '1;
          vminus[k] = '0;
          score[k] = ed2l_pkg::LEN_W'(m);
        end
        word_len[0] = it.dict_length_a;
        word_len[1] = it.dict_length_b;
        pos = '0;
        if (it.dict_length_a == 0 && it.dict_length_b == 0) begin
          r.distance_a = score[0];
          r.distance_b = score[1];
          dist_q.push_back(r);
        end
      end
      ed2l_pkg::MODE_STEP: begin
        if (pos < longest) begin
          column_update(0, it.dict_letter_a, m);
          column_update(1, it.dict_letter_b, m);
          pos = pos + 16'd1;
          if (pos == longest) begin
            r.distance_a = score[0];
            r.distance_b = score[1];
            dist_q.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic flag_error(input string what, input int want_v, input int got_v);
    n_errors++;
    if (n_errors <= 10)
      $display("mismatch %s: expected %0d, got %0d (t=%0t)", what, want_v, got_v, $time);
  endtask

  // Driver: bursts of requests separated by random gaps
  int burst_left;
  int gap_left;
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (item_valid && !item_stall) advance_model(item);
      if (!item_valid || !item_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          item_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          item <= pending_q.pop_front();
          item_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(3))
              0, 1: gap_left = 0;
              2: gap_left = $urandom_range(1, 3);
              default: gap_left = $urandom_range(4, 12);
            endcase
          end
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern, plus a long hold-off on request
  int pat_left;
  int stall_pct;
  int hold_left;
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      pat_left = 0;
      stall_pct = 0;
      hold_left = 0;
    end else begin
      if (hold_start) hold_left = HOLD_CYCLES;
      if (pat_left == 0) begin
        pat_left = $urandom_range(10, 80);
        case ($urandom_range(4))
          0, 1: stall_pct = 0;
          2: stall_pct = 25;
          3: stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end else begin
        pat_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Monitor: compare each delivered result with the oldest prediction
  ed2l_pkg::result_t want;
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (dist_q.size() == 0) begin
        flag_error("unexpected result, distance_a", -1, result.distance_a);
      end else begin
        want = dist_q.pop_front();
        if (result.distance_a !== want.distance_a)
          flag_error("distance_a", want.distance_a, result.distance_a);
        if (result.distance_b !== want.distance_b)
          flag_error("distance_b", want.distance_b, result.distance_b);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Request builders
  function automatic ed2l_pkg::item_t rand_item();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[$bits(ed2l_pkg::item_t)-1:0];
  endfunction

  // Ignored request with random payload
  function automatic ed2l_pkg::item_t nop_item();
    ed2l_pkg::item_t it;
    it = rand_item();
    it.mode = MODE_NOP;
    return it;
  endfunction

  function automatic logic [ed2l_pkg::LETTER_W-1:0] rand_code();
    if ($urandom_range(99) < 85) return ed2l_pkg::LETTER_W'($urandom_range(ALPHA - 1));
    return ed2l_pkg::LETTER_W'($urandom_range(ALPHA, 31));
  endfunction

  // Dictionary letter, often one that occurs in the query
  function automatic logic [ed2l_pkg::LETTER_W-1:0] dict_code();
    if (shadow_m > 0 && $urandom_range(1) == 1)
      return query_shadow[$urandom_range(shadow_m - 1)];
    return rand_code();
  endfunction

  function automatic logic [ed2l_pkg::LEN_W-1:0] pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 85) return ed2l_pkg::LEN_W'($urandom_range(0, 10));
    if (r < 97) return ed2l_pkg::LEN_W'($urandom_range(11, 40));
    return ed2l_pkg::LEN_W'($urandom_range(41, 90));
  endfunction

  task automatic queue_request(input ed2l_pkg::item_t it);
    pending_q.push_back(it);
    if (it.mode != MODE_NOP) n_items++;
  endtask

  task automatic push_load(input int idx, input logic [ed2l_pkg::LETTER_W-1:0] code);
    ed2l_pkg::item_t it;
    it = rand_item();
    it.mode = ed2l_pkg::MODE_LOAD;
    it.query_index = ed2l_pkg::QIDX_W'(idx);
    it.query_letter = code;
    query_shadow[idx] = code;
    query_set[idx] = 1'b1;
    queue_request(it);
  endtask

  task automatic push_begin(input logic [ed2l_pkg::LEN_W-1:0] la,
                            input logic [ed2l_pkg::LEN_W-1:0] lb);
    ed2l_pkg::item_t it;
    it = rand_item();
    it.mode = ed2l_pkg::MODE_BEGIN;
    it.dict_length_a = la;
    it.dict_length_b = lb;
    queue_request(it);
  endtask

  task automatic push_step(input logic [ed2l_pkg::LETTER_W-1:0] ca,
                           input logic [ed2l_pkg::LETTER_W-1:0] cb);
    ed2l_pkg::item_t it;
    it = rand_item();
    it.mode = ed2l_pkg::MODE_STEP;
    it.dict_letter_a = ca;
    it.dict_letter_b = cb;
    queue_request(it);
  endtask

  // A complete comparison: begin plus enough steps to finish both words
  task automatic push_word(input logic [ed2l_pkg::LEN_W-1:0] la,
                           input logic [ed2l_pkg::LEN_W-1:0] lb);
    push_begin(la, lb);
    repeat ((la > lb) ? la : lb) push_step(dict_code(), dict_code());
  endtask

  // Wait until the block has nothing left to deliver
  task automatic settle();
    @(posedge clk);
    while (pending_q.size() != 0 || item_valid || dist_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Query length write while idle; then make sure every used entry is loaded
  task automatic write_qlen(input logic [ed2l_pkg::QLEN_W-1:0] v);
    settle();
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    query_len = v;
    shadow_m = (v > QMAX) ? QMAX : int'(v);
    for (int i = 0; i < shadow_m; i++)
      if (!query_set[i]) push_load(i, rand_code());
  endtask

  int phase;
  int r;
  logic [ed2l_pkg::QLEN_W-1:0] qv;
  logic [ed2l_pkg::LEN_W-1:0] la, lb;
  initial begin
    for (int k = 0; k < 2; k++) begin
      vplus[k] = '1;
      vminus[k] = '0;
      score[k] = '0;
      word_len[k] = '0;
    end
    for (int i = 0; i < QMAX; i++) begin
      qstore[i] = '0;
      query_set[i] = 1'b0;
      query_shadow[i] = '0;
    end
    pos = '0;
    query_len = '0;
    shadow_m = 0;
    n_items = 0;
    n_errors = 0;
    cycles = 0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Empty query: both lengths zero, then scores equal to word lengths
    push_begin(16'd0, 16'd0);
    push_begin(16'd3, 16'd1);
    push_step(5'd0, 5'd25);
    push_step(5'd31, 5'd0);
    push_step(5'd25, 5'd26);
    // step with no comparison open, and an ignored request
    push_step(5'd3, 5'd4);
    queue_request(nop_item());

    // Five-letter query, second word shorter so its tail is ignored
    write_qlen(7'd5);
    push_load(0, 5'd7);
    push_load(1, 5'd4);
    push_load(2, 5'd11);
    push_load(3, 5'd11);
    push_load(4, 5'd14);
    push_load(63, 5'd31);
    push_begin(16'd5, 16'd4);
    push_step(5'd25, 5'd7);
    push_step(5'd0, 5'd4);
    push_step(5'd11, 5'd11);
    push_step(5'd11, 5'd15);
    push_step(5'd14, 5'd31);
    push_begin(16'd0, 16'd0);
    // longest lengths, abandoned after a few letters
    push_begin(16'hFFFF, 16'h0000);
    push_step(5'd7, 5'd4);
    push_step(5'd4, 5'd7);
    push_begin(16'h0000, 16'hFFFF);
    push_step(5'd14, 5'd0);

    // Query length changed while a comparison is open
    push_begin(16'd3, 16'd2);
    push_step(5'd7, 5'd11);
    write_qlen(7'd6);
    push_step(5'd4, 5'd14);
    push_step(5'd11, 5'd11);

    // Random phases, each with its own query length
    phase = 0;
    while (n_items < 1450) begin
      case (phase)
        0: qv = 7'd64;
        1: qv = 7'd127;
        2: qv = 7'd1;
        default: begin
          case ($urandom_range(9))
            0: qv = 7'd0;
            1: qv = 7'd1;
            2: qv = 7'd64;
            3: qv = ed2l_pkg::QLEN_W'($urandom_range(65, 127));
            default: qv = ed2l_pkg::QLEN_W'($urandom_range(2, 63));
          endcase
        end
      endcase
      write_qlen(qv);

      // Receiver holds off while instant results pile up
      if (phase == 4) begin
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        repeat (40) push_begin(16'd0, 16'd0);
      end

      repeat ($urandom_range(4, 12)) begin
        r = $urandom_range(99);
        if (r < 70) begin
          push_word(pick_len(), pick_len());
        end else if (r < 78) begin
          push_load($urandom_range(QMAX - 1), rand_code());
        end else if (r < 86) begin
          if ($urandom_range(1) == 1) push_step(dict_code(), dict_code());
          else queue_request(nop_item());
        end else begin
          // broken sequence: begin with any lengths, stop after a few letters
          la = ed2l_pkg::LEN_W'($urandom);
          lb = ed2l_pkg::LEN_W'($urandom);
          push_begin(la, lb);
          repeat ($urandom_range(0, 5)) push_step(dict_code(), dict_code());
        end
      end
      phase++;
    end

    settle();
    repeat (10) @(posedge clk);
    if (n_errors == 0 && dist_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
